// ===== rtl/vcp_pkg.sv =====
package vcp_pkg;

  localparam int STORE_LEN   = 6;
  localparam int COUNT_W     = 3;
  localparam int POT_COUNT   = 10;
  localparam int IDX_W       = 4;
  localparam int VOL_CHARS   = 3;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(STORE_LEN);
  localparam logic [COUNT_W-1:0] COUNT_MAX  = 3'd7;

  // ASCII codes
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_U     = 8'h55;

  // digipot addresses and select commands
  localparam logic [7:0] ADDR_A = 8'b01011100;
  localparam logic [7:0] ADDR_B = 8'b01011000;
  localparam logic [7:0] ADDR_C = 8'b01011010;
  localparam logic [7:0] CMD_P0 = 8'h00;
  localparam logic [7:0] CMD_P1 = 8'b00010000;
  localparam logic [7:0] CMD_P2 = 8'h60;
  localparam logic [7:0] CMD_P3 = 8'h70;

  // one classified request, front to back
  typedef struct packed {
    logic                      led;
    logic                      mute;
    logic                      send;
    logic [IDX_W-1:0]          idx;
    logic [VOL_CHARS-1:0][7:0] vol;
  } work_t;

  function automatic logic [7:0] pot_addr(input logic [IDX_W-1:0] idx);
    logic [7:0] a;
    case (idx)
      4'd0, 4'd1:                    a = ADDR_A;
      4'd2, 4'd4, 4'd6, 4'd8:        a = ADDR_B;
      4'd3, 4'd5, 4'd7, 4'd9:        a = ADDR_C;
      default:                       a = 8'h00;
    endcase
    return a;
  endfunction

  function automatic logic [7:0] pot_cmd(input logic [IDX_W-1:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0, 4'd2, 4'd3: c = CMD_P0;
      4'd1, 4'd4, 4'd5: c = CMD_P1;
      4'd6, 4'd7:       c = CMD_P2;
      4'd8, 4'd9:       c = CMD_P3;
      default:          c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF) ||
           (c == CH_CR) || (c == CH_LF);
  endfunction

  // atoi over three characters, modulo 256
  function automatic logic [7:0] parse_volume(input logic [VOL_CHARS-1:0][7:0] vol);
    logic [7:0] acc;
    logic       neg;
    logic [1:0] phase; // 0 blanks, 1 digits, 2 done
    logic [7:0] c;
    acc   = 8'h00;
    neg   = 1'b0;
    phase = 2'd0;
    for (int i = 0; i < VOL_CHARS; i++) begin
      c = vol[i];
      if (phase == 2'd0) begin
        if (is_blank(c)) begin
          phase = 2'd0;
        end else if (c == CH_PLUS || c == CH_MINUS) begin
          neg   = (c == CH_MINUS);
          phase = 2'd1;
        end else if (is_digit(c)) begin
          acc   = 8'((acc * 8'd10) + {4'h0, c[3:0]});
          phase = 2'd1;
        end else begin
          phase = 2'd2;
        end
      end else if (phase == 2'd1) begin
        if (is_digit(c)) begin
          acc = 8'((acc * 8'd10) + {4'h0, c[3:0]});
        end else begin
          phase = 2'd2;
        end
      end
    end
    return neg ? 8'(8'h00 - acc) : acc;
  endfunction

endpackage

// ===== rtl/volume_command_parser_top.sv =====
// Volume command parser. Each request is one received UART character on
// rx_byte; every request yields exactly one result. Characters build a
// command such as "1L=255" or "MM=TRU"; CR or LF ends it. A command is
// acted on only when exactly six characters preceded the terminator and
// the third is '='. "MM=TRU" mutes the amplifier, any other "MM..." unmutes
// it; anything else selects a digipot by channel digit ('M' = master) and
// L/R, and when the pot exists send_pot is set with the address byte,
// command byte and an atoi-style wiper value (mod 256). Otherwise the three
// bytes read zero. led_on is high while a command is being collected.
// Throughput is one request per cycle while full is low and pop keeps
// up; a request passes from push through the classify queue and the
// result register to the ports, and waits there while pop holds off.
module volume_command_parser_top #(
  parameter int QUEUE_DEPTH = vcp_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  // request side
  input  logic       push,
  output logic       full,
  input  logic [7:0] rx_byte,
  // result side
  output logic       empty,
  input  logic       pop,
  output logic       led_on,
  output logic       amp_muted,
  output logic       send_pot,
  output logic [7:0] pot_address,
  output logic [7:0] pot_command,
  output logic [7:0] wiper_value
);
  import vcp_pkg::*;

  work_t front_work;
  work_t back_work;
  logic  take;
  logic  q_empty;
  logic  q_pop;

  // front classifies in the cycle the character is taken
  assign take = push && !full;

  vcp_front u_front (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .rx_byte (rx_byte),
    .work    (front_work)
  );

  vcp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (take),
    .wdata (front_work),
    .full  (full),
    .pop   (q_pop),
    .rdata (back_work),
    .empty (q_empty)
  );

  // back does table lookup and volume conversion into the result register
  vcp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .work        (back_work),
    .work_empty  (q_empty),
    .work_pop    (q_pop),
    .pop         (pop),
    .empty       (empty),
    .led_on      (led_on),
    .amp_muted   (amp_muted),
    .send_pot    (send_pot),
    .pot_address (pot_address),
    .pot_command (pot_command),
    .wiper_value (wiper_value)
  );

endmodule

// ===== rtl/vcp_front.sv =====
module vcp_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           take,
  input  logic [7:0]     rx_byte,
  output vcp_pkg::work_t work
);
  import vcp_pkg::*;

  logic [7:0]         store [STORE_LEN];
  logic [COUNT_W-1:0] count;
  logic               mute;
  logic               mute_next;
  logic               term;
  logic               check;
  logic               is_mm;
  logic               lr;
  logic [3:0]         ch;

  assign term  = (rx_byte == CH_CR) || (rx_byte == CH_LF);
  assign check = term && (count == COUNT_FULL) && (store[2] == CH_EQ);
  assign is_mm = (store[0] == CH_M) && (store[1] == CH_M);
  assign lr    = (store[1] == CH_L) ? 1'b0 : 1'b1;
  assign ch    = is_digit(store[0]) ? store[0][3:0] : 4'd0;

  always_comb begin
    mute_next = mute;
    if (check && is_mm) begin
      mute_next = (store[3] == CH_T) && (store[4] == CH_R) && (store[5] == CH_U);
    end
  end

  always_comb begin
    work.led  = !term;
    work.mute = mute_next;
    // channels 5 to 7 land past the table; 8 and 9 wrap onto it
    work.send = check && !is_mm && (ch < 4'd5);
    work.idx  = {ch[2:0], lr};
    work.vol  = {store[5], store[4], store[3]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      mute  <= 1'b0;
    end else if (take) begin
      mute <= mute_next;
      if (term) begin
        count <= '0;
      end else if (count < COUNT_FULL) begin
        count <= count + 1'b1;
      end else begin
        count <= COUNT_MAX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && !term && count < COUNT_FULL) begin
      store[count] <= rx_byte;
    end
  end

endmodule

// ===== rtl/vcp_queue.sv =====
module vcp_queue #(
  parameter int DEPTH = vcp_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  vcp_pkg::work_t wdata,
  output logic           full,
  input  logic           pop,
  output vcp_pkg::work_t rdata,
  output logic           empty
);
  import vcp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  work_t            mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

// ===== rtl/vcp_back.sv =====
module vcp_back (
  input  logic           clk,
  input  logic           rst,
  input  vcp_pkg::work_t work,
  input  logic           work_empty,
  output logic           work_pop,
  input  logic           pop,
  output logic           empty,
  output logic           led_on,
  output logic           amp_muted,
  output logic           send_pot,
  output logic [7:0]     pot_address,
  output logic [7:0]     pot_command,
  output logic [7:0]     wiper_value
);
  import vcp_pkg::*;

  logic out_valid;

  assign empty    = !out_valid;
  assign work_pop = !work_empty && (!out_valid || pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (work_pop) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  // table lookup and volume conversion; bytes are zero when no write goes out
  always_ff @(posedge clk) begin
    if (work_pop) begin
      led_on      <= work.led;
      amp_muted   <= work.mute;
      send_pot    <= work.send;
      pot_address <= work.send ? pot_addr(work.idx) : 8'h00;
      pot_command <= work.send ? pot_cmd(work.idx) : 8'h00;
      wiper_value <= work.send ? parse_volume(work.vol) : 8'h00;
    end
  end

endmodule
